// ===== rtl/bmb_pkg.sv =====
// shared types and constants for the block mean binariser
// no dependencies
package bmb_pkg;

  localparam int MAX_FRAME_WIDTH   = 1024;
  localparam int MAX_FRAME_HEIGHT  = 1024;
  localparam int MAX_BLOCK_COLUMNS = 256;
  localparam int MAX_BLOCK_SIDE    = 64;
  localparam int MIN_BLOCK_SIDE    = 4;

  localparam int BS_W     = 7;   // block_size register width
  localparam int DIM_W    = 11;  // frame_width / frame_height register width
  localparam int POS_W    = 10;  // pixel position within the frame
  localparam int OFF_W    = 6;   // pixel offset within a block
  localparam int IDX_W    = 8;   // block row / column index
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 20;  // one column accumulator
  localparam int CNT_W    = 13;  // pixel count of one block
  localparam int COL_AW   = $clog2(MAX_BLOCK_COLUMNS);
  localparam int LIGHT_SH = 7;   // threshold 128 as a shift

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [BS_W-1:0]  BS_RESET = 7'd20;
  localparam logic [DIM_W-1:0] W_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] H_RESET  = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } bmb_in_t;

  typedef struct packed {
    logic             block_light;
    logic [IDX_W-1:0] block_row;
    logic [IDX_W-1:0] block_col;
    logic             frame_done;
  } bmb_out_t;

endpackage

// ===== rtl/bmb_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module bmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/block_mean_binarizer.sv =====
// block mean binariser top level: counters, accumulator update, result register
// depends on bmb_pkg and bmb_ram
// usage
// - pixels arrive in raster order on in_data; a transfer happens at a clock edge
//   with in_valid high and in_stall low; frame_start restarts the counters
// - one result per finished block leaves on out_data with out_valid; the
//   receiver holds it with out_stall, and the result stays until transferred
// - the user writes registers via the cfg_ port (cfg_ready is always high) only
//   while no pixel is in flight (not enforced); values clamp to their legal range
// pipeline and throughput
// - one pixel per clock while the output is not stalled; a block result reaches
//   out_valid through the update stage and then the output register
// - the per-column sums live in one ram with a registered read; the read is
//   issued as the pixel is taken and the update stage writes the sum back
// - while the output register is full and stalled, a pixel that finishes a
//   block waits in the update stage and in_stall rises
// reset
// - synchronous, active low; counters clear and registers return to 20 x
//   640 x 480; the sum ram is not cleared, as each entry is written by the
//   first pixel of its block before its value is used
module block_mean_binarizer
  import bmb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bmb_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmb_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // clamped configuration
  logic [BS_W-1:0]  bs_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [BS_W-1:0]  bs_clamp;
  logic [DIM_W-1:0] dim_clamp;
  logic [DIM_W-1:0] h_clamp;

  // position counters
  logic [POS_W-1:0] px_r, py_r;
  logic [OFF_W-1:0] ox_r, oy_r;
  logic [IDX_W-1:0] bx_r, by_r;
  logic [POS_W-1:0] px_nxt, py_nxt;
  logic [OFF_W-1:0] ox_nxt, oy_nxt;
  logic [IDX_W-1:0] bx_nxt, by_nxt;

  // current pixel after a possible frame restart
  logic [POS_W-1:0] px_c, py_c;
  logic [OFF_W-1:0] ox_c, oy_c;
  logic [IDX_W-1:0] bx_c, by_c;
  logic             line_end, last_line, ox_last, oy_last, end_x, end_y;
  logic [BS_W-1:0]  ox_inc, oy_inc;
  logic [CNT_W-1:0] count_c;

  // update stage
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_first_r, s1_emit_r, s1_done_r;
  logic [CNT_W-1:0] s1_count_r;
  logic [IDX_W-1:0] s1_row_r, s1_col_r;
  logic             fwd_r;
  logic [SUM_W-1:0] fwd_sum_r;
  logic [SUM_W-1:0] ram_rdata, operand, s1_sum;
  logic [SUM_W-1:0] threshold;
  logic             s1_adv, accept, out_take;

  // output register
  logic     out_valid_r;
  bmb_out_t out_data_r;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign s1_adv    = s1_v_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp register writes to their legal range
  always_comb begin
    bs_clamp = cfg_wdata[BS_W-1:0];
    if (cfg_wdata[BS_W-1:0] < BS_W'(MIN_BLOCK_SIDE)) begin
      bs_clamp = BS_W'(MIN_BLOCK_SIDE);
    end else if (cfg_wdata[BS_W-1:0] > BS_W'(MAX_BLOCK_SIDE)) begin
      bs_clamp = BS_W'(MAX_BLOCK_SIDE);
    end
    dim_clamp = cfg_wdata;
    if (cfg_wdata == '0) begin
      dim_clamp = DIM_W'(1);
    end else if (cfg_wdata > DIM_W'(MAX_FRAME_WIDTH)) begin
      dim_clamp = DIM_W'(MAX_FRAME_WIDTH);
    end
    h_clamp = cfg_wdata;
    if (cfg_wdata == '0) begin
      h_clamp = DIM_W'(1);
    end else if (cfg_wdata > DIM_W'(MAX_FRAME_HEIGHT)) begin
      h_clamp = DIM_W'(MAX_FRAME_HEIGHT);
    end
  end

  // position of the incoming pixel and where the counters go next
  always_comb begin
    if (in_data.frame_start) begin
      px_c = '0; py_c = '0; ox_c = '0; oy_c = '0; bx_c = '0; by_c = '0;
    end else begin
      px_c = px_r; py_c = py_r; ox_c = ox_r; oy_c = oy_r; bx_c = bx_r; by_c = by_r;
    end
    ox_inc    = {1'b0, ox_c} + BS_W'(1);
    oy_inc    = {1'b0, oy_c} + BS_W'(1);
    line_end  = ({1'b0, px_c} + DIM_W'(1)) >= w_r;
    last_line = ({1'b0, py_c} + DIM_W'(1)) >= h_r;
    ox_last   = ox_inc >= bs_r;
    oy_last   = oy_inc >= bs_r;
    end_x     = line_end || ox_last;
    end_y     = last_line || oy_last;
    count_c   = CNT_W'(ox_inc) * CNT_W'(oy_inc);

    px_nxt = px_c; py_nxt = py_c; ox_nxt = ox_c; oy_nxt = oy_c;
    bx_nxt = bx_c; by_nxt = by_c;
    if (line_end) begin
      px_nxt = '0; ox_nxt = '0; bx_nxt = '0;
      if (last_line) begin
        py_nxt = '0; oy_nxt = '0; by_nxt = '0;
      end else begin
        py_nxt = py_c + POS_W'(1);
        if (oy_last) begin
          oy_nxt = '0;
          by_nxt = by_c + IDX_W'(1);
        end else begin
          oy_nxt = oy_c + OFF_W'(1);
        end
      end
    end else begin
      px_nxt = px_c + POS_W'(1);
      if (ox_last) begin
        ox_nxt = '0;
        bx_nxt = bx_c + IDX_W'(1);
      end else begin
        ox_nxt = ox_c + OFF_W'(1);
      end
    end
  end

  // column sums, read as a pixel is taken, written back from the update stage
  bmb_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_BLOCK_COLUMNS)
  ) u_col_sums (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r[COL_AW-1:0]),
    .wdata (s1_sum),
    .re    (accept),
    .raddr (bx_c[COL_AW-1:0]),
    .rdata (ram_rdata)
  );

  // forwarded sum covers a write and read of one column at the same edge
  always_comb begin
    operand   = fwd_r ? fwd_sum_r : ram_rdata;
    s1_sum    = (s1_first_r ? '0 : operand) + SUM_W'(s1_pix_r);
    threshold = SUM_W'({s1_count_r, LIGHT_SH'(0)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BS_RESET;
      w_r         <= W_RESET;
      h_r         <= H_RESET;
      px_r        <= '0;
      py_r        <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      bx_r        <= '0;
      by_r        <= '0;
      s1_v_r      <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_SIZE:   bs_r <= bs_clamp;
          CFG_FRAME_WIDTH:  w_r  <= dim_clamp;
          CFG_FRAME_HEIGHT: h_r  <= h_clamp;
          default:          ;
        endcase
      end

      if (accept) begin
        px_r   <= px_nxt;
        py_r   <= py_nxt;
        ox_r   <= ox_nxt;
        oy_r   <= oy_nxt;
        bx_r   <= bx_nxt;
        by_r   <= by_nxt;
        s1_v_r <= 1'b1;
        fwd_r  <= s1_adv && (s1_col_r[COL_AW-1:0] == bx_c[COL_AW-1:0]);
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      // output register: a new result may load in the cycle the old one leaves
      if (s1_adv && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_data.pixel_value;
      s1_first_r <= (ox_c == '0) && (oy_c == '0);
      s1_emit_r  <= end_x && end_y;
      s1_done_r  <= line_end && last_line;
      s1_count_r <= count_c;
      s1_row_r   <= by_c;
      s1_col_r   <= bx_c;
      fwd_sum_r  <= s1_sum;
    end
    if (s1_adv && s1_emit_r) begin
      out_data_r.block_light <= s1_sum > threshold;
      out_data_r.block_row   <= s1_row_r;
      out_data_r.block_col   <= s1_col_r;
      out_data_r.frame_done  <= s1_done_r;
    end
  end

endmodule
